// File: hw/rtl/eprc_pkg.sv
// Shared types and constants for the echo-pulse ranging controller.
// Holds the beat structs, configuration register layout and status codes.
// No dependencies.
package eprc_pkg;

  // Counter width default; the top level may override it in the range 16 to 32.
  localparam int COUNT_BITS_DEF = 27;

  localparam int WIDTH_BITS = 27;
  localparam int DIST_BITS  = 21;
  localparam int TIME_BITS  = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 27;

  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0]  DIST_MAX  = {DIST_BITS{1'b1}};

  // One centimetre of range is 58 microseconds of echo.
  localparam int CM_DIV = 58;
  localparam int REM_BITS = 6;
  localparam logic [REM_BITS-1:0] REM_LAST = REM_BITS'(CM_DIV - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_TIME  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RISE_TO   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALL_TO   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [TIME_BITS-1:0]  LOW_TIME_RST = 8'd2;
  localparam logic [TIME_BITS-1:0]  PULSE_RST    = 8'd20;
  localparam logic [WIDTH_BITS-1:0] RISE_TO_RST  = 27'd30000;
  localparam logic [WIDTH_BITS-1:0] FALL_TO_RST  = 27'd100000000;

  // Measurement status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RISE_TO = 2'd1;
  localparam logic [1:0] ST_FALL_TO = 2'd2;

  typedef struct packed {
    logic [TIME_BITS-1:0]  low_time_us;
    logic [TIME_BITS-1:0]  pulse_time_us;
    logic [WIDTH_BITS-1:0] rise_timeout_us;
    logic [WIDTH_BITS-1:0] fall_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_beat_t;

  typedef struct packed {
    logic                  trig_out;
    logic                  busy_res;
    logic                  done_res;
    logic [1:0]            status;
    logic [WIDTH_BITS-1:0] pulse_width_us;
    logic [DIST_BITS-1:0]  range_cm;
  } out_beat_t;

endpackage

// File: hw/rtl/eprc_seq.sv
// Measurement sequencer: trigger timing, echo timeouts and width capture.
// Depends on eprc_pkg. Advances one tick when step is high.
module eprc_seq
  import eprc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  cfg_t      cfg,
  input  in_beat_t  beat,
  output out_beat_t res
);

  localparam int CMPW = (COUNT_BITS > WIDTH_BITS) ? COUNT_BITS : WIDTH_BITS;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_LOW  = 5'b00010,
    PH_HIGH = 5'b00100,
    PH_WAIT = 5'b01000,
    PH_MEAS = 5'b10000
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [REM_BITS-1:0]   rem_r, rem_nxt;
  logic [DIST_BITS-1:0]  quo_r, quo_nxt;
  logic [WIDTH_BITS-1:0] width_r, width_nxt;
  logic [DIST_BITS-1:0]  dist_r, dist_nxt;
  logic [1:0]            status_r, status_nxt;

  logic                  cnt_sat;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CMPW-1:0]       cnt_ext;
  logic                  trig;
  logic                  done;

  assign cnt_sat = &cnt_r;
  assign cnt_inc = cnt_sat ? cnt_r : cnt_r + 1'b1;
  assign cnt_ext = CMPW'(cnt_r);

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    width_nxt  = width_r;
    dist_nxt   = dist_r;
    status_nxt = status_r;
    trig       = 1'b0;
    done       = 1'b0;
    case (phase_r)
      PH_LOW: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= COUNT_BITS'(cfg.low_time_us)) begin
          phase_nxt = PH_HIGH;
          cnt_nxt   = '0;
        end
      end
      PH_HIGH: begin
        trig    = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= COUNT_BITS'(cfg.pulse_time_us)) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end
      end
      PH_WAIT: begin
        if (beat.echo_level) begin
          // The rising tick already counts as one tick of echo.
          phase_nxt = PH_MEAS;
          cnt_nxt   = COUNT_BITS'(1);
          rem_nxt   = REM_BITS'(1);
          quo_nxt   = '0;
        end else if (cnt_ext >= CMPW'(cfg.rise_timeout_us)) begin
          phase_nxt  = PH_IDLE;
          cnt_nxt    = '0;
          status_nxt = ST_RISE_TO;
          done       = 1'b1;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_MEAS: begin
        if (!beat.echo_level) begin
          width_nxt  = (cnt_ext > CMPW'(WIDTH_MAX)) ? WIDTH_MAX : WIDTH_BITS'(cnt_r);
          dist_nxt   = quo_r;
          status_nxt = ST_OK;
          phase_nxt  = PH_IDLE;
          cnt_nxt    = '0;
          done       = 1'b1;
        end else if (cnt_ext >= CMPW'(cfg.fall_timeout_us)) begin
          status_nxt = ST_FALL_TO;
          phase_nxt  = PH_IDLE;
          cnt_nxt    = '0;
          done       = 1'b1;
        end else if (!cnt_sat) begin
          // Quotient and remainder by 58 follow the count one tick at a time.
          cnt_nxt = cnt_inc;
          if (rem_r == REM_LAST) begin
            rem_nxt = '0;
            quo_nxt = (quo_r == DIST_MAX) ? quo_r : quo_r + 1'b1;
          end else begin
            rem_nxt = rem_r + 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (beat.start_req) begin
          phase_nxt = (cfg.low_time_us == '0) ? PH_HIGH : PH_LOW;
          cnt_nxt   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      width_r  <= '0;
      dist_r   <= '0;
      status_r <= ST_OK;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      width_r  <= width_nxt;
      dist_r   <= dist_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_comb begin
    res.trig_out       = trig;
    res.busy_res       = (phase_nxt != PH_IDLE);
    res.done_res       = done;
    res.status         = status_nxt;
    res.pulse_width_us = width_nxt;
    res.range_cm       = dist_nxt;
  end

endmodule

// File: hw/rtl/echo_pulse_ranging_controller.sv
// Top level of the echo-pulse ranging controller: handshakes, registers, result beat.
// Depends on eprc_pkg and eprc_seq.
//
// Each input beat is one microsecond tick carrying a start request and the sampled
// echo pin level; each accepted beat yields exactly one result beat, registered, in the
// next cycle. The block takes one beat every cycle: the whole tick update (trigger
// timing, timeout compares, width capture and the running divide by 58) is one pass
// of logic in the sequencer, and in_ready drops only while the output register holds
// a beat that the consumer has not yet taken. A start request while a measurement
// is running is ignored. Distance needs no divider: the sequencer keeps quotient and
// remainder by 58 alongside the echo counter. Configuration writes are taken every
// cycle and should be made while no measurement is in progress.
module echo_pulse_ranging_controller
  import eprc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_beat_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_beat_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t      cfg_r;
  out_beat_t seq_res;
  out_beat_t out_data_r;
  logic      out_valid_r, out_valid_nxt;
  logic      step;

  // Configuration registers; each write keeps only the bits its register holds.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_time_us     <= LOW_TIME_RST;
      cfg_r.pulse_time_us   <= PULSE_RST;
      cfg_r.rise_timeout_us <= RISE_TO_RST;
      cfg_r.fall_timeout_us <= FALL_TO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_TIME: cfg_r.low_time_us     <= cfg_data[TIME_BITS-1:0];
        REG_PULSE:    cfg_r.pulse_time_us   <= cfg_data[TIME_BITS-1:0];
        REG_RISE_TO:  cfg_r.rise_timeout_us <= cfg_data[WIDTH_BITS-1:0];
        REG_FALL_TO:  cfg_r.fall_timeout_us <= cfg_data[WIDTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // A new tick enters whenever the output register is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  eprc_seq #(
    .COUNT_BITS(COUNT_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg_r),
    .beat  (in_data),
    .res   (seq_res)
  );

  // Output register: the result of every accepted tick is held until taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every accepted tick leaves a result beat waiting in the next cycle.
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted tick produced no result beat");

  // A measurement that ends leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> !out_data_r.busy_res)
    else $error("done reported while still busy");

  // The trigger is only driven while a sequence runs.
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.trig_out) |-> out_data_r.busy_res)
    else $error("trigger high outside a measurement");

  // A timeout never changes the reported width.
  a_timeout_keeps_width: assert property (@(posedge clk) disable iff (!rst_n)
    (step && seq_res.done_res && (seq_res.status != ST_OK))
      |=> $stable(out_data_r.pulse_width_us) || !$past(out_valid_r))
    else $error("width changed on a timeout");

endmodule
